// ===== src/spdc_pkg.sv =====
`timescale 1ns / 1ps
// spdc_pkg: shared types, constants and the crc-8 byte update for the deframer
// used by every module of serial_packet_deframer_crc8_unit; no dependencies

package spdc_pkg;

   localparam int PAYLOAD_MAX = 16;
   localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);
   localparam int IDX_W       = $clog2(PAYLOAD_MAX);
   localparam int QUEUE_DEPTH = 2;
   localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
   localparam int BUF_AW      = SLOT_W + IDX_W;
   localparam int BUF_DEPTH   = QUEUE_DEPTH * PAYLOAD_MAX;

   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic [1:0] CSR_FIRST_HDR  = 2'd0;
   localparam logic [1:0] CSR_SECOND_HDR = 2'd1;

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_TYPE = 3'd2,
      PH_SEQ  = 3'd3,
      PH_LEN  = 3'd4,
      PH_DATA = 3'd5,
      PH_CRC  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      B_IDLE = 2'd0,
      B_LOAD = 2'd1,
      B_SEND = 2'd2
   } back_state_type;

   // one checked frame waiting to be played out
   typedef struct packed {
      logic [7:0]       frame_type;
      logic [7:0]       seq_number;
      logic [LEN_W-1:0] payload_len;
   } desc_type;

   // payload buffer write from the parser
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [IDX_W-1:0]  idx;
      logic [7:0]        data;
   } buf_wr_type;

   // reflected crc-8, lsb first
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== src/spdc_front.sv =====
`timescale 1ns / 1ps
// spdc_front: byte parser - header hunt, field capture, crc check, payload write
// depends on spdc_pkg

module spdc_front
   import spdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        first_hdr,
   input  logic [7:0]        second_hdr,
   input  logic              queue_full,
   input  logic [SLOT_W-1:0] wr_slot,
   output buf_wr_type        buf_wr,
   output logic              push,
   output desc_type          push_desc
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       seq_ff, seq_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   logic             take;
   logic [LEN_W-1:0] count_inc;

   // a free payload bank is needed for the frame being parsed
   assign req_tready = !queue_full;
   assign take       = req_tvalid && req_tready;
   assign count_inc  = count_ff + LEN_W'(1);

   assign push_desc = '{frame_type: type_ff, seq_number: seq_ff, payload_len: len_ff};

   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      push        = 1'b0;
      buf_wr.en   = 1'b0;
      buf_wr.slot = wr_slot;
      buf_wr.idx  = count_ff[IDX_W-1:0];
      buf_wr.data = rx_byte;
      if (take) begin
         unique case (phase_ff)
            PH_HDR2: begin
               phase_in = (rx_byte == second_hdr) ? PH_TYPE : PH_HDR1;
            end
            PH_TYPE: begin
               type_in  = rx_byte;
               crc_in   = crc8_feed(8'h00, rx_byte);
               phase_in = PH_SEQ;
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               crc_in   = crc8_feed(crc_ff, rx_byte);
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if ({1'b0, rx_byte} <= 9'(PAYLOAD_MAX)) begin
                  len_in   = rx_byte[LEN_W-1:0];
                  count_in = '0;
                  crc_in   = crc8_feed(crc_ff, rx_byte);
                  phase_in = (rx_byte != 8'h00) ? PH_DATA : PH_CRC;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_DATA: begin
               if (count_ff < len_ff) begin
                  buf_wr.en = 1'b1;
                  crc_in    = crc8_feed(crc_ff, rx_byte);
                  if (count_inc >= len_ff) begin
                     count_in = '0;
                     phase_in = PH_CRC;
                  end else begin
                     count_in = count_inc;
                  end
               end else begin
                  count_in = '0;
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               phase_in = PH_HDR1;
               push     = (rx_byte == crc_ff);
            end
            default: begin
               phase_in = (rx_byte == first_hdr) ? PH_HDR2 : PH_HDR1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
         type_ff  <= '0;
         seq_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         crc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         seq_ff   <= seq_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

`ifndef SYNTHESIS
   // a frame is only queued from the crc phase
   assert property (@(posedge clock) disable iff (reset) push |-> phase_ff == PH_CRC)
      else $error("push outside crc phase");
   // payload writes never pass the frame length
   assert property (@(posedge clock) disable iff (reset)
      buf_wr.en |-> ({1'b0, buf_wr.idx} < len_ff))
      else $error("payload write beyond length");
`endif

endmodule

// ===== src/spdc_desc_queue.sv =====
`timescale 1ns / 1ps
// spdc_desc_queue: small fifo of checked frame descriptors between parser and player
// the slot index of each entry also selects its payload bank; depends on spdc_pkg

module spdc_desc_queue
   import spdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  desc_type          push_desc,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output logic [SLOT_W-1:0] wr_slot,
   output logic [SLOT_W-1:0] rd_slot,
   output desc_type          head_desc
);

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [SLOT_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [SLOT_W:0]   count_ff, count_in;

   assign full      = (count_ff == (SLOT_W + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign wr_slot   = wr_ptr_ff;
   assign rd_slot   = rd_ptr_ff;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (SLOT_W + 1)'(1);
         2'b01:   count_in = count_ff - (SLOT_W + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // depth is a power of two, so pointers wrap by themselves
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + SLOT_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + SLOT_W'(1);
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

// ===== src/spdc_back.sv =====
`timescale 1ns / 1ps
// spdc_back: payload buffer and result player, one result beat per payload byte
// depends on spdc_pkg; fed by spdc_front (buffer writes) and spdc_desc_queue

module spdc_back
   import spdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  buf_wr_type        buf_wr,
   input  logic              queue_empty,
   input  logic [SLOT_W-1:0] rd_slot,
   input  desc_type          head_desc,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        frame_type,
   output logic [7:0]        seq_number,
   output logic [LEN_W-1:0]  payload_len,
   output logic [7:0]        payload_byte,
   output logic [IDX_W-1:0]  byte_index,
   output logic              last_of_frame
);

   logic [7:0]       buf_mem [BUF_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             load;
   logic             is_last;

   logic [7:0]       out_type_ff, out_seq_ff, out_byte_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buf_mem[{buf_wr.slot, buf_wr.idx}] <= buf_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[{rd_slot, rd_idx}];
      end
   end

   // zero length frames end on their only beat
   assign is_last = (head_desc.payload_len == '0) ||
                    (({1'b0, idx_ff} + LEN_W'(1)) == head_desc.payload_len);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rd_en    = 1'b0;
      rd_idx   = idx_ff;
      load     = 1'b0;
      pop      = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               rd_en    = 1'b1;
               rd_idx   = '0;
               idx_in   = '0;
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            load     = 1'b1;
            state_in = B_SEND;
         end
         B_SEND: begin
            if (rsp_tready) begin
               if (out_last_ff) begin
                  pop      = 1'b1;
                  idx_in   = '0;
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  rd_en    = 1'b1;
                  rd_idx   = idx_ff + IDX_W'(1);
                  state_in = B_LOAD;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_type_ff <= head_desc.frame_type;
         out_seq_ff  <= head_desc.seq_number;
         out_len_ff  <= head_desc.payload_len;
         out_byte_ff <= (head_desc.payload_len == '0) ? 8'h00 : rd_data_ff;
         out_idx_ff  <= idx_ff;
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid    = (state_ff == B_SEND);
   assign frame_type    = out_type_ff;
   assign seq_number    = out_seq_ff;
   assign payload_len   = out_len_ff;
   assign payload_byte  = out_byte_ff;
   assign byte_index    = out_idx_ff;
   assign last_of_frame = out_last_ff;

`ifndef SYNTHESIS
   // the head frame is held until its last beat has gone out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_LOAD || state_ff == B_SEND) |-> !queue_empty)
      else $error("player running with empty queue");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (rsp_tvalid && rsp_tready && last_of_frame))
      else $error("frame released before its last beat");
`endif

endmodule

// ===== src/serial_packet_deframer_crc8_unit.sv =====
`timescale 1ns / 1ps
// serial_packet_deframer_crc8_unit: top level of the serial packet deframer
// depends on spdc_pkg, spdc_front, spdc_desc_queue, spdc_back

// Receives serial bytes on the req stream, one byte per beat, and hunts for a
// frame: first header byte, second header byte, type, sequence, length (0..16),
// that many payload bytes, then a reflected crc-8 byte (poly 0x8c, init 0)
// over type, sequence, length and payload. A good frame comes out on the rsp
// stream as one beat per payload byte with tlast on the final one, or a
// single beat with zero payload when the length is zero; bad frames and
// oversize lengths are dropped without a trace. The parser takes one byte
// per clock; it holds req_tready low only while both payload banks hold
// checked frames not yet played out. Each player beat passes through a load
// state for the registered read of the payload buffer before it is offered.
// Header bytes are set through the csr write channel (index 0 first header,
// index 1 second header, other indexes ignored), always ready; write them
// while the block is idle.

module serial_packet_deframer_crc8_unit
   import spdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] frame_type, [15:8] seq_number,
                                    // [20:16] payload_len, [28:21] payload_byte,
                                    // [32:29] byte_index, [39:33] zero
   output logic        rsp_tlast,   // last_of_frame
   // header configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // header registers
   logic [7:0] first_hdr_ff, first_hdr_in;
   logic [7:0] second_hdr_ff, second_hdr_in;

   // front to queue and buffer
   buf_wr_type        buf_wr;
   logic              push;
   desc_type          push_desc;
   logic              queue_full;
   logic              queue_empty;
   logic [SLOT_W-1:0] wr_slot;
   logic [SLOT_W-1:0] rd_slot;
   desc_type          head_desc;
   logic              pop;

   // result fields before packing
   logic [7:0]       frame_type;
   logic [7:0]       seq_number;
   logic [LEN_W-1:0] payload_len;
   logic [7:0]       payload_byte;
   logic [IDX_W-1:0] byte_index;

   assign csr_ready = 1'b1;

   always_comb begin
      first_hdr_in  = first_hdr_ff;
      second_hdr_in = second_hdr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_HDR:  first_hdr_in  = csr_data;
            CSR_SECOND_HDR: second_hdr_in = csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_hdr_ff  <= '0;
         second_hdr_ff <= '0;
      end else begin
         first_hdr_ff  <= first_hdr_in;
         second_hdr_ff <= second_hdr_in;
      end
   end

   // parser: classifies each byte and fills the payload bank of the next slot
   spdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata),
      .first_hdr  (first_hdr_ff),
      .second_hdr (second_hdr_ff),
      .queue_full (queue_full),
      .wr_slot    (wr_slot),
      .buf_wr     (buf_wr),
      .push       (push),
      .push_desc  (push_desc)
   );

   // checked frames waiting for the player
   spdc_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .wr_slot   (wr_slot),
      .rd_slot   (rd_slot),
      .head_desc (head_desc)
   );

   // player: walks the head frame's payload bank, one beat per byte
   spdc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .buf_wr        (buf_wr),
      .queue_empty   (queue_empty),
      .rd_slot       (rd_slot),
      .head_desc     (head_desc),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .frame_type    (frame_type),
      .seq_number    (seq_number),
      .payload_len   (payload_len),
      .payload_byte  (payload_byte),
      .byte_index    (byte_index),
      .last_of_frame (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, byte_index, payload_byte, payload_len, seq_number, frame_type};

endmodule

// ===== tb/sv/serial_packet_deframer_crc8_unit_test.sv =====
`timescale 1ns / 1ps
// serial_packet_deframer_crc8_unit_test: self-checking bench for the serial packet deframer
// depends on spdc_pkg and serial_packet_deframer_crc8_unit; needs nothing else

module serial_packet_deframer_crc8_unit_test;
   import spdc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 40;   // a full 16-beat playout plus margin
   localparam int LONG_HOLD     = 600;  // long output stall, fills both payload banks
   localparam int RANDOM_ITEMS  = 270;
   localparam int RANDOM_BEATS  = 48;
   localparam int PHASE_ITEMS   = 70;
   localparam int UNCHECKED     = -1;

   localparam logic [7:0] CRC8_REFLECTED_POLY = 8'h8C;
   localparam logic [1:0] CSR_SPARE_A = 2'd2;   // not a register, must be ignored
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   // rsp_tdata seen as fields, frame_type in the lowest bits
   typedef struct packed {
      logic [6:0]       pad;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic [LEN_W-1:0] payload_len;
      logic [7:0]       seq_number;
      logic [7:0]       frame_type;
   } result_word_type;

   typedef struct packed {
      logic            last;
      result_word_type word;
   } payload_beat_type;

   typedef enum {
      ROW_RX,          // send the byte as given
      ROW_CRC_OK,      // send the running crc of the frame
      ROW_CRC_BAD,     // send the running crc inverted
      ROW_CSR_FIRST,
      ROW_CSR_SECOND,
      ROW_CSR_SPARE
   } stim_kind_type;

   typedef struct {
      stim_kind_type kind;
      logic [7:0]    value;
      int            results;   // beats this byte must release, or UNCHECKED
   } stim_row_type;

   localparam int N_DIRECTED = 30;

   // directed walk: typed beat counts are the obvious ones
   stim_row_type directed_rows [N_DIRECTED] = '{
      // reset headers are both zero; empty frame gives a single beat
      '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'hFF, 0},
      '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_CRC_OK, 8'h00, 1},
      // extreme headers; a spare index must not touch them
      '{ROW_CSR_FIRST, 8'hFF, UNCHECKED}, '{ROW_CSR_SECOND, 8'h00, UNCHECKED},
      '{ROW_CSR_SPARE, 8'h55, UNCHECKED},
      // second header mismatch, the stray byte is not taken as a new first header
      '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'h00, 0},
      // length one above the limit drops the frame
      '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'h12, 0},
      '{ROW_RX, 8'h34, 0}, '{ROW_RX, 8'h11, 0},
      // bad crc on an empty frame, dropped without a beat
      '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'h80, 0},
      '{ROW_RX, 8'h01, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_CRC_BAD, 8'h00, 0},
      // one-byte frame with extreme contents
      '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'h00, 0}, '{ROW_RX, 8'h00, 0},
      '{ROW_RX, 8'hFF, 0}, '{ROW_RX, 8'h01, 0}, '{ROW_RX, 8'hFF, 0},
      '{ROW_CRC_OK, 8'h00, 1}
   };

   // dut ports, all inputs known from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_FIRST_HDR;
   logic [7:0]  csr_data   = 8'h00;

   // deframer mirror: header settings and parse state, reset values
   logic [7:0] hdr_first   = 8'h00;
   logic [7:0] hdr_second  = 8'h00;
   phase_type  rx_phase    = PH_HDR1;
   logic [7:0] cur_type    = 8'h00;
   logic [7:0] cur_seq     = 8'h00;
   logic [4:0] cur_len     = 5'd0;
   logic [4:0] fill_count  = 5'd0;
   logic [7:0] crc_acc     = 8'h00;
   logic [7:0] payload_mem [PAYLOAD_MAX];

   payload_beat_type pending_payload_beats [$];

   int  mismatch_count     = 0;
   int  beats_checked      = 0;
   int  beats_predicted    = 0;
   int  rx_bytes           = 0;
   int  framed_bytes       = 0;
   int  phase_bytes        = 0;
   int  csr_writes         = 0;
   int  input_stall_cycles = 0;
   int  cycle_count        = 0;
   bit  no_idle            = 1'b0;   // both sides run without gaps
   bit  rsp_hold_req       = 1'b0;   // asks the sink for one long stall

   serial_packet_deframer_crc8_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // reflected crc-8, one byte lsb first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       lsb;
      c = crc ^ b;
      repeat (8) begin
         lsb = c[0];
         c = {1'b0, c[7:1]};
         if (lsb) c = c ^ CRC8_REFLECTED_POLY;
      end
      return c;
   endfunction

   function automatic void queue_payload_beat(input logic [7:0] pbyte, input int idx,
                                              input logic last);
      payload_beat_type beat;
      beat = '0;
      beat.word.frame_type   = cur_type;
      beat.word.seq_number   = cur_seq;
      beat.word.payload_len  = cur_len;
      beat.word.payload_byte = pbyte;
      beat.word.byte_index   = idx[IDX_W-1:0];
      beat.last              = last;
      pending_payload_beats.push_back(beat);
   endfunction

   // advance the mirror by one accepted byte, queue the beats it releases
   function automatic int deframe_byte(input logic [7:0] b);
      int n;
      n = 0;
      case (rx_phase)
         PH_HDR2: rx_phase = (b == hdr_second) ? PH_TYPE : PH_HDR1;
         PH_TYPE: begin
            cur_type = b;
            crc_acc  = crc8_step(8'h00, b);
            rx_phase = PH_SEQ;
         end
         PH_SEQ: begin
            cur_seq  = b;
            crc_acc  = crc8_step(crc_acc, b);
            rx_phase = PH_LEN;
         end
         PH_LEN: begin
            if (b <= PAYLOAD_MAX) begin
               cur_len    = b[4:0];
               fill_count = 5'd0;
               crc_acc    = crc8_step(crc_acc, b);
               rx_phase   = (b != 8'h00) ? PH_DATA : PH_CRC;
            end else begin
               rx_phase = PH_HDR1;
            end
         end
         PH_DATA: begin
            if (fill_count < cur_len) begin
               payload_mem[fill_count[IDX_W-1:0]] = b;
               fill_count = fill_count + 5'd1;
               crc_acc    = crc8_step(crc_acc, b);
               if (fill_count >= cur_len) begin
                  fill_count = 5'd0;
                  rx_phase   = PH_CRC;
               end
            end else begin
               fill_count = 5'd0;
               rx_phase   = PH_CRC;
            end
         end
         PH_CRC: begin
            rx_phase = PH_HDR1;
            if (b == crc_acc) begin
               if (cur_len == 5'd0) begin
                  queue_payload_beat(8'h00, 0, 1'b1);
                  n = 1;
               end else begin
                  for (int i = 0; i < int'(cur_len); i++) begin
                     queue_payload_beat(payload_mem[i], i, (i + 1 == int'(cur_len)));
                  end
                  n = int'(cur_len);
               end
            end
         end
         default: rx_phase = (b == hdr_first) ? PH_HDR2 : PH_HDR1;
      endcase
      beats_predicted += n;
      return n;
   endfunction

   function automatic void check_field(input string what, input logic [39:0] want,
                                       input logic [39:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // one byte on the req stream, random gap in front, mirror updated on the beat
   task automatic send_byte(input logic [7:0] b, output int n_beats);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      n_beats = deframe_byte(b);
      rx_bytes++;
   endtask

   // sender pause: nothing offered until every queued beat is out, then let the
   // parser finish any byte that releases nothing
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_payload_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIRST_HDR) hdr_first = val;
      else if (idx == CSR_SECOND_HDR) hdr_second = val;
      csr_writes++;
   endtask

   // one random sequence under the current headers: mostly good frames, the rest
   // noise, wrong second header, bad crc, oversize length or a cut-off frame
   task automatic send_frame_mix();
      int         pick;
      int         len;
      int         keep;
      int         n_dummy;
      logic [7:0] len_byte;
      logic [7:0] crc;
      logic [7:0] bval;
      logic [7:0] seq_q [$];
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // line noise, mostly ignored by the hunt
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), n_dummy);
      end else begin
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = PAYLOAD_MAX;
            default: len = $urandom_range(1, 6);
         endcase
         len_byte = (pick >= 22 && pick < 27) ? 8'($urandom_range(PAYLOAD_MAX + 1, 255))
                                              : 8'(len);
         seq_q.push_back(hdr_first);
         seq_q.push_back((pick >= 8 && pick < 14) ? hdr_second ^ 8'($urandom_range(1, 255))
                                                  : hdr_second);
         bval = 8'($urandom_range(0, 255));
         seq_q.push_back(bval);
         crc = crc8_step(8'h00, bval);
         bval = 8'($urandom_range(0, 255));
         seq_q.push_back(bval);
         crc = crc8_step(crc, bval);
         seq_q.push_back(len_byte);
         crc = crc8_step(crc, len_byte);
         repeat (len) begin
            bval = 8'($urandom_range(0, 255));
            seq_q.push_back(bval);
            crc = crc8_step(crc, bval);
         end
         if (pick >= 14 && pick < 22) crc = crc ^ 8'($urandom_range(1, 255));
         seq_q.push_back(crc);
         if (pick >= 27 && pick < 32) begin
            keep = $urandom_range(1, seq_q.size() - 1);
            while (seq_q.size() > keep) void'(seq_q.pop_back());
         end
         foreach (seq_q[i]) send_byte(seq_q[i], n_dummy);
         framed_bytes += seq_q.size();
         phase_bytes  += seq_q.size();
      end
   endtask

   // result sink: random gap before each beat, one long stall on request
   initial begin : rsp_sink
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // compare every accepted beat with the oldest queued one
   always @(posedge clock) begin : beat_checker
      payload_beat_type want;
      result_word_type  got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_payload_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual data 0x%0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_payload_beats.pop_front();
            check_field("frame_type", want.word.frame_type, got.frame_type);
            check_field("seq_number", want.word.seq_number, got.seq_number);
            check_field("payload_len", want.word.payload_len, got.payload_len);
            check_field("payload_byte", want.word.payload_byte, got.payload_byte);
            check_field("byte_index", want.word.byte_index, got.byte_index);
            check_field("tdata padding", want.word.pad, got.pad);
            check_field("tlast", want.last, rsp_tlast);
            beats_checked++;
         end
      end
   end

   // watchdog and backpressure count
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats still queued", $time,
                  pending_payload_beats.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int         n_beats;
      int         phase_idx;
      int         rand_start_bytes;
      int         rand_start_beats;
      bit         paused;
      logic [7:0] hdr_pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      if (rsp_tvalid !== 1'b0) begin
         $display("%0t: rsp_tvalid after reset, expected 0, actual %b", $time, rsp_tvalid);
         mismatch_count++;
      end

      // directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         n_beats = UNCHECKED;
         case (directed_rows[r].kind)
            ROW_RX:         send_byte(directed_rows[r].value, n_beats);
            ROW_CRC_OK:     send_byte(crc_acc, n_beats);
            ROW_CRC_BAD:    send_byte(~crc_acc, n_beats);
            ROW_CSR_FIRST:  write_csr(CSR_FIRST_HDR, directed_rows[r].value);
            ROW_CSR_SECOND: write_csr(CSR_SECOND_HDR, directed_rows[r].value);
            ROW_CSR_SPARE:  write_csr(CSR_SPARE_A, directed_rows[r].value);
         endcase
         if (directed_rows[r].results != UNCHECKED && n_beats != directed_rows[r].results) begin
            $display("%0t: table row %0d beat count, expected %0d, actual %0d",
                     $time, r, directed_rows[r].results, n_beats);
            mismatch_count++;
         end
      end

      // random phases, headers changed only while the block is idle
      phase_idx        = 0;
      paused           = 1'b0;
      rand_start_bytes = framed_bytes;
      rand_start_beats = beats_predicted;
      while (framed_bytes - rand_start_bytes < RANDOM_ITEMS ||
             beats_predicted - rand_start_beats < RANDOM_BEATS) begin
         hdr_pick = 8'($urandom_range(0, 255));
         case (phase_idx % 4)
            0: begin
               write_csr(CSR_FIRST_HDR, hdr_pick);
               write_csr(CSR_SECOND_HDR, 8'($urandom_range(0, 255)));
            end
            1: begin
               // opposite extremes
               write_csr(CSR_FIRST_HDR, 8'h00);
               write_csr(CSR_SECOND_HDR, 8'hFF);
            end
            2: begin
               // both header bytes alike
               write_csr(CSR_FIRST_HDR, hdr_pick);
               write_csr(CSR_SECOND_HDR, hdr_pick);
            end
            default: begin
               write_csr(CSR_FIRST_HDR, hdr_pick);
               write_csr(CSR_SECOND_HDR, ~hdr_pick);
               write_csr(CSR_SPARE_B, 8'($urandom_range(0, 255)));
            end
         endcase
         no_idle = (phase_idx % 4 == 1);
         // long output stall while frames keep coming, fills both banks
         if (phase_idx == 2) rsp_hold_req = 1'b1;
         phase_bytes = 0;
         while (phase_bytes < PHASE_ITEMS) begin
            if (phase_idx == 3 && !paused && phase_bytes >= PHASE_ITEMS / 2) begin
               drain_and_settle();
               paused = 1'b1;
            end
            send_frame_mix();
         end
         phase_idx++;
      end
      no_idle = 1'b0;

      drain_and_settle();
      if (pending_payload_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_payload_beats.size());
         mismatch_count++;
      end

      $display("covered %0d rx bytes (%0d framed) and %0d result beats over %0d csr writes",
               rx_bytes, framed_bytes, beats_checked, csr_writes);
      $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/spdc_pkg.sv
src/spdc_front.sv
src/spdc_desc_queue.sv
src/spdc_back.sv
src/serial_packet_deframer_crc8_unit.sv
tb/sv/serial_packet_deframer_crc8_unit_test.sv
